// ===== design/f32a_pkg.sv =====
// Package with the beat types and constants of the single-precision adder.
package f32a_pkg;

    localparam int unsigned ExpMaxFinite = 254;
    localparam int unsigned SigBits      = 24;
    localparam int unsigned FracBits     = 23;

    typedef struct packed {
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] sum_bits;
        logic        status;
    } t_out_beat;

    // Operands after unpacking and swap: larger magnitude first.
    typedef struct packed {
        logic        special;
        logic        infinite;
        logic        sign;
        logic        sub;
        logic [7:0]  exp;
        logic [7:0]  diff;
        logic [23:0] big;
        logic [23:0] lesser;
    } t_align_in;

    // Sum of the aligned significands, with guard, round and sticky.
    typedef struct packed {
        logic        special;
        logic        infinite;
        logic        sign;
        logic [8:0]  exp;
        logic [27:0] sum;
    } t_norm_in;

    // Normalized significand, before rounding.
    typedef struct packed {
        logic        special;
        logic        infinite;
        logic        sign;
        logic [8:0]  exp;
        logic [26:0] sig;
    } t_round_in;

endpackage

// ===== design/float32_adder.sv =====
// This block adds two IEEE 754 single-precision operands, rounding to nearest even, and
// returns the sum pattern with an infinite flag. It is a four-stage pipeline (unpack,
// align and add, normalize, round) that accepts one beat every cycle while no stall
// reaches its input; each result passes through r_s1, r_s2, r_s3 and r_s4 in turn.
// A stall holds only the run of full stages at the output; empty stages keep filling.
module float32_adder
    import f32a_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);

    t_align_in n_s1, r_s1;
    t_norm_in  n_s2, r_s2;
    t_round_in n_s3, r_s3;
    t_out_beat n_s4, r_s4;
    logic [3:0] r_v;
    logic [3:0] adv;

    f32a_unpack u_unpack (.i_beat(i_data), .o_align(n_s1));
    f32a_align  u_align  (.i_align(r_s1), .o_norm(n_s2));
    f32a_norm   u_norm   (.i_norm(r_s2), .o_round(n_s3));
    f32a_round  u_round  (.i_round(r_s3), .o_beat(n_s4));

    always_comb begin
        adv[3] = !r_v[3] || !i_stall;
        adv[2] = !r_v[2] || adv[3];
        adv[1] = !r_v[1] || adv[2];
        adv[0] = !r_v[0] || adv[1];
    end

    assign o_stall = !adv[0];
    assign o_valid = r_v[3];
    assign o_data  = r_s4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 4'd0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            if (adv[1]) begin
                r_v[1] <= r_v[0];
            end
            if (adv[2]) begin
                r_v[2] <= r_v[1];
            end
            if (adv[3]) begin
                r_v[3] <= r_v[2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s1 <= n_s1;
        end
        if (adv[1]) begin
            r_s2 <= n_s2;
        end
        if (adv[2]) begin
            r_s3 <= n_s3;
        end
        if (adv[3]) begin
            r_s4 <= n_s4;
        end
    end

`ifndef SYNTHESIS
    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v == 4'hF))
        else $error("input stalled with an empty stage");
    a_inf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status) |-> (o_data.sum_bits == 32'd0))
        else $error("infinite status with nonzero sum");
`endif

endmodule

// ===== design/f32a_unpack.sv =====
// First stage: unpacks both operands, flags special cases and swaps them.
module f32a_unpack
    import f32a_pkg::*;
(
    input  t_in_beat  i_beat,
    output t_align_in o_align
);

    logic [7:0]  ea, eb, e1, e2;
    logic [23:0] ma, mb;
    logic        swap;

    always_comb begin
        ea = (i_beat.operand_a[30:23] == 8'd0) ? 8'd1 : i_beat.operand_a[30:23];
        eb = (i_beat.operand_b[30:23] == 8'd0) ? 8'd1 : i_beat.operand_b[30:23];
        ma = {(i_beat.operand_a[30:23] != 8'd0), i_beat.operand_a[22:0]};
        mb = {(i_beat.operand_b[30:23] != 8'd0), i_beat.operand_b[22:0]};
        swap = (ea < eb) || ((ea == eb) && (ma < mb));
        e1 = swap ? eb : ea;
        e2 = swap ? ea : eb;
        o_align.infinite = (i_beat.operand_a[30:23] == 8'hFF)
                        || (i_beat.operand_b[30:23] == 8'hFF);
        o_align.special  = o_align.infinite
            || ((i_beat.operand_a ^ i_beat.operand_b) == 32'h8000_0000)
            || ((i_beat.operand_a[30:0] == 31'd0) && (i_beat.operand_b[30:0] == 31'd0));
        o_align.sign   = swap ? i_beat.operand_b[31] : i_beat.operand_a[31];
        o_align.sub    = i_beat.operand_a[31] ^ i_beat.operand_b[31];
        o_align.exp    = e1;
        o_align.diff   = e1 - e2;
        o_align.big    = swap ? mb : ma;
        o_align.lesser = swap ? ma : mb;
    end

endmodule

// ===== design/f32a_align.sv =====
// Second stage: aligns the smaller significand and adds or subtracts.
module f32a_align
    import f32a_pkg::*;
(
    input  t_align_in i_align,
    output t_norm_in  o_norm
);

    logic [26:0] big, lesser, shifted, lost_mask;
    logic        sticky;

    always_comb begin
        big       = {i_align.big, 3'b000};
        lesser    = {i_align.lesser, 3'b000};
        lost_mask = 27'd0;
        sticky    = 1'b0;
        if (i_align.diff >= 8'd27) begin
            shifted = {26'd0, (lesser != 27'd0)};
        end else begin
            lost_mask = (27'd1 << i_align.diff[4:0]) - 27'd1;
            sticky    = (lesser & lost_mask) != 27'd0;
            shifted   = (lesser >> i_align.diff[4:0]) | {26'd0, sticky};
        end
        o_norm.special  = i_align.special;
        o_norm.infinite = i_align.infinite;
        o_norm.sign     = i_align.sign;
        o_norm.exp      = {1'b0, i_align.exp};
        o_norm.sum      = i_align.sub ? ({1'b0, big} - {1'b0, shifted})
                                      : ({1'b0, big} + {1'b0, shifted});
    end

endmodule

// ===== design/f32a_norm.sv =====
// Third stage: renormalizes the sum with a leading-zero count and bounded shift.
module f32a_norm
    import f32a_pkg::*;
(
    input  t_norm_in  i_norm,
    output t_round_in o_round
);

    logic [4:0]  lz;
    logic [8:0]  room, amt;
    logic [26:0] r;

    always_comb begin
        lz = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (i_norm.sum[i]) begin
                lz = 5'(26 - i);
            end
        end
        room = i_norm.exp - 9'd1;
        amt  = ({4'd0, lz} < room) ? {4'd0, lz} : room;
        r    = i_norm.sum[26:0] << amt[4:0];
        o_round.special  = i_norm.special;
        o_round.infinite = i_norm.infinite;
        o_round.sign     = i_norm.sign;
        if (i_norm.sum[27]) begin
            o_round.sig = i_norm.sum[27:1] | {26'd0, i_norm.sum[0]};
            o_round.exp = i_norm.exp + 9'd1;
        end else begin
            o_round.sig = r;
            o_round.exp = r[26] ? (i_norm.exp - amt) : 9'd0;
        end
    end

endmodule

// ===== design/f32a_round.sv =====
// Fourth stage: rounds to nearest even and packs the result.
module f32a_round
    import f32a_pkg::*;
(
    input  t_round_in i_round,
    output t_out_beat o_beat
);

    logic [24:0] mant;
    logic [8:0]  ex;

    always_comb begin
        mant = {1'b0, i_round.sig[26:3]};
        ex   = i_round.exp;
        if (i_round.sig[2] && ((i_round.sig[1:0] != 2'd0) || i_round.sig[3])) begin
            mant = mant + 25'd1;
        end
        if (mant[24]) begin
            mant = mant >> 1;
            ex   = ex + 9'd1;
        end
        if ((ex == 9'd0) && mant[23]) begin
            ex = 9'd1;
        end
        o_beat.status = i_round.infinite;
        if (i_round.special) begin
            o_beat.sum_bits = 32'd0;
        end else if (ex > 9'(ExpMaxFinite)) begin
            o_beat.sum_bits = {i_round.sign, 8'hFF, 23'd0};
        end else begin
            o_beat.sum_bits = {i_round.sign, ex[7:0], mant[22:0]};
        end
    end

endmodule
